FILE: hw/rtl/tcwaf_pkg.sv
// ----------------------------------------------------------------------------
// tcwaf_pkg
// Shared types, constants and frame layout for the two-channel window
// average framer.
// ----------------------------------------------------------------------------
package tcwaf_pkg;

  localparam int WINDOW_MAX_SAMPLES = 256;

  localparam int DATA_W    = 12;
  localparam int CHAN_W    = 4;
  localparam int COUNT_W   = $clog2(WINDOW_MAX_SAMPLES + 1);
  localparam int SUM_W     = DATA_W + $clog2(WINDOW_MAX_SAMPLES);
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam int FRAME_LEN = 11;
  localparam int BYTE_IDX_W = $clog2(FRAME_LEN);

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = CHAN_W;

  // config register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_X_CHANNEL = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_Y_CHANNEL = CFG_INDEX_W'(1);

  localparam logic [CHAN_W-1:0] X_CHANNEL_RESET = CHAN_W'(4);
  localparam logic [CHAN_W-1:0] Y_CHANNEL_RESET = CHAN_W'(5);

  // item function codes
  localparam logic FUNC_SAMPLE     = 1'b0;
  localparam logic FUNC_WINDOW_END = 1'b1;

  // frame characters
  localparam logic [7:0] CHR_AT      = 8'h40;
  localparam logic [7:0] CHR_VERSION = 8'h01;
  localparam logic [7:0] CHR_R       = 8'h52;
  localparam logic [7:0] CHR_E       = 8'h65;
  localparam logic [7:0] CHR_N       = 8'h6E;
  localparam logic [7:0] CHR_D       = 8'h64;
  localparam logic [7:0] CHR_NL      = 8'h0A;

  // frame byte positions
  localparam logic [BYTE_IDX_W-1:0] POS_AT   = BYTE_IDX_W'(0);
  localparam logic [BYTE_IDX_W-1:0] POS_VER  = BYTE_IDX_W'(1);
  localparam logic [BYTE_IDX_W-1:0] POS_R    = BYTE_IDX_W'(2);
  localparam logic [BYTE_IDX_W-1:0] POS_XLO  = BYTE_IDX_W'(3);
  localparam logic [BYTE_IDX_W-1:0] POS_XHI  = BYTE_IDX_W'(4);
  localparam logic [BYTE_IDX_W-1:0] POS_YLO  = BYTE_IDX_W'(5);
  localparam logic [BYTE_IDX_W-1:0] POS_YHI  = BYTE_IDX_W'(6);
  localparam logic [BYTE_IDX_W-1:0] POS_E    = BYTE_IDX_W'(7);
  localparam logic [BYTE_IDX_W-1:0] POS_N    = BYTE_IDX_W'(8);
  localparam logic [BYTE_IDX_W-1:0] POS_D    = BYTE_IDX_W'(9);
  localparam logic [BYTE_IDX_W-1:0] POS_LAST = BYTE_IDX_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic              func;
    logic [CHAN_W-1:0] sample_channel;
    logic [DATA_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic sample_en;
    logic div_load;
    logic div_sel;     // 0 = x, 1 = y
    logic div_step;
    logic held_write;
    logic win_clear;
    logic byte_next;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic byte_last;
  } status_t;

  function automatic logic [7:0] frame_byte_f(
    input logic [BYTE_IDX_W-1:0] idx,
    input logic [DATA_W-1:0]     hx,
    input logic [DATA_W-1:0]     hy
  );
    logic [15:0] wx;
    logic [15:0] wy;
    logic [7:0]  b;
    wx = 16'(hx);
    wy = 16'(hy);
    unique case (idx)
      POS_AT:   b = CHR_AT;
      POS_VER:  b = CHR_VERSION;
      POS_R:    b = CHR_R;
      POS_XLO:  b = wx[7:0];
      POS_XHI:  b = wx[15:8];
      POS_YLO:  b = wy[7:0];
      POS_YHI:  b = wy[15:8];
      POS_E:    b = CHR_E;
      POS_N:    b = CHR_N;
      POS_D:    b = CHR_D;
      POS_LAST: b = CHR_NL;
      default:  b = CHR_NL;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/tcwaf_ctrl.sv
// ----------------------------------------------------------------------------
// tcwaf_ctrl
// Controller: takes items, sequences the shared divider over both channels
// and walks the output frame.
// ----------------------------------------------------------------------------
module tcwaf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output tcwaf_pkg::cmd_t    cmd,
  input  tcwaf_pkg::status_t status
);
  import tcwaf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_SEND
  } state_t;

  state_t state;
  logic   sel;

  logic in_take;
  logic out_take;

  assign in_stall = (state != S_IDLE);
  assign in_take  = (state == S_IDLE) && in_valid;
  assign out_take = out_valid && !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.div_sel    = sel;
    cmd.sample_en  = in_take && (in_func == FUNC_SAMPLE);
    cmd.div_load   = (state == S_LOAD);
    cmd.div_step   = (state == S_DIV) && !status.div_done;
    cmd.held_write = (state == S_DIV) && status.div_done;
    cmd.win_clear  = (state == S_DIV) && status.div_done && sel;
    cmd.byte_next  = (state == S_SEND) && out_take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take && (in_func == FUNC_WINDOW_END)) begin
            state <= S_LOAD;
            sel   <= 1'b0;
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (status.div_done) begin
            if (sel) begin
              state     <= S_SEND;
              out_valid <= 1'b1;
            end else begin
              state <= S_LOAD;
              sel   <= 1'b1;
            end
          end
        end
        S_SEND: begin
          if (out_take && status.byte_last) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/tcwaf_dpath.sv
// ----------------------------------------------------------------------------
// tcwaf_dpath
// Datapath: channel registers, window sums and counts, a shared restoring
// divider, held averages and the frame byte select.
// ----------------------------------------------------------------------------
module tcwaf_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  tcwaf_pkg::in_item_t               in_data,
  input  logic                              cfg_write,
  input  logic [tcwaf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tcwaf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  tcwaf_pkg::cmd_t                   cmd,
  output tcwaf_pkg::status_t                status,
  output tcwaf_pkg::out_item_t              out_data
);
  import tcwaf_pkg::*;

  logic [CHAN_W-1:0]     x_channel;
  logic [CHAN_W-1:0]     y_channel;
  logic [SUM_W-1:0]      x_sum;
  logic [SUM_W-1:0]      y_sum;
  logic [COUNT_W-1:0]    x_count;
  logic [COUNT_W-1:0]    y_count;
  logic [DATA_W-1:0]     held_x;
  logic [DATA_W-1:0]     held_y;

  logic [SUM_W-1:0]      quo;
  logic [COUNT_W-1:0]    rem;
  logic [COUNT_W-1:0]    divisor;
  logic                  divisor_zero;
  logic [DIV_CNT_W-1:0]  div_cnt;

  logic [BYTE_IDX_W-1:0] byte_idx;

  logic [COUNT_W:0]      trial;
  logic                  trial_ge;
  logic [COUNT_W:0]      trial_diff;
  logic                  hit_x;
  logic                  hit_y;

  // one quotient bit per step
  assign trial      = {rem, quo[SUM_W-1]};
  assign trial_ge   = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};

  // equal channel registers count for x only
  assign hit_x = (in_data.sample_channel == x_channel);
  assign hit_y = !hit_x && (in_data.sample_channel == y_channel);

  assign status.div_done  = (div_cnt == '0);
  assign status.byte_last = (byte_idx == POS_LAST);

  assign out_data.frame_byte = frame_byte_f(byte_idx, held_x, held_y);
  assign out_data.last_byte  = (byte_idx == POS_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_channel <= X_CHANNEL_RESET;
      y_channel <= Y_CHANNEL_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_X_CHANNEL) begin
        x_channel <= cfg_data;
      end else if (cfg_index == CFG_Y_CHANNEL) begin
        y_channel <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_sum   <= '0;
      y_sum   <= '0;
      x_count <= '0;
      y_count <= '0;
    end else if (cmd.win_clear) begin
      x_sum   <= '0;
      y_sum   <= '0;
      x_count <= '0;
      y_count <= '0;
    end else if (cmd.sample_en) begin
      if (hit_x && (x_count < COUNT_W'(WINDOW_MAX_SAMPLES))) begin
        x_sum   <= x_sum + SUM_W'(in_data.sample_value);
        x_count <= x_count + COUNT_W'(1);
      end
      if (hit_y && (y_count < COUNT_W'(WINDOW_MAX_SAMPLES))) begin
        y_sum   <= y_sum + SUM_W'(in_data.sample_value);
        y_count <= y_count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_load) begin
      div_cnt <= DIV_CNT_W'(SUM_W);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo          <= cmd.div_sel ? y_sum : x_sum;
      divisor      <= cmd.div_sel ? y_count : x_count;
      divisor_zero <= cmd.div_sel ? (y_count == '0) : (x_count == '0);
      rem          <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[SUM_W-2:0], trial_ge};
      rem <= trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x <= '0;
      held_y <= '0;
    end else if (cmd.held_write && !divisor_zero) begin
      if (cmd.div_sel) begin
        held_y <= quo[DATA_W-1:0];
      end else begin
        held_x <= quo[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= '0;
    end else if (cmd.byte_next) begin
      byte_idx <= (byte_idx == POS_LAST) ? '0 : byte_idx + BYTE_IDX_W'(1);
    end
  end

endmodule

FILE: hw/rtl/two_channel_window_average_framer.sv
// ----------------------------------------------------------------------------
// two_channel_window_average_framer
// Sums and counts tagged samples of two channels and, on a window end,
// emits an 11-byte frame carrying both truncated window means.
// ----------------------------------------------------------------------------
// sample item: taken while the block is idle, next item may follow in the next cycle
// window end: x then y go through the shared divider (load, then steps until done),
//   then 11 frame bytes at one per cycle while out_stall is low
// no input is taken from window end until the last frame byte leaves
// rst (synchronous): channels 4 and 5, sums, counts and held means cleared
module two_channel_window_average_framer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tcwaf_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tcwaf_pkg::out_item_t              out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcwaf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tcwaf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tcwaf_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tcwaf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  tcwaf_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/tcwaf_checker.sv
// ----------------------------------------------------------------------------
// tcwaf_checker
// Port-level checks on item flow of the framer, bound to the top level.
// ----------------------------------------------------------------------------
module tcwaf_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input tcwaf_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input tcwaf_pkg::out_item_t out_data
);
  import tcwaf_pkg::*;

  // no frame byte is shown while inputs are taken
  a_idle_no_out: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("frame byte shown while input open");

  // a window end closes the input side
  a_end_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.func == FUNC_WINDOW_END)) |=> in_stall)
    else $error("input open after window end");

  // frame stops after its last byte
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.last_byte) |=> !out_valid)
    else $error("frame continues after last byte");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled frame byte changed");

endmodule

bind two_channel_window_average_framer tcwaf_checker u_tcwaf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: verif/two_channel_window_average_framer_tb.sv
// ----------------------------------------------------------------------------
// two_channel_window_average_framer_tb
// Self-checking bench for the window average framer. Tagged samples and
// window ends are pushed through the input channel under several channel
// settings. Each window end is turned into the expected 11-byte frame by a
// local running-mean predictor, and every output byte is compared in order.
// Both sides idle in random bursts. A long receiver hold-off backs the block
// up, and a full window checks the per-channel sample cap.
// ----------------------------------------------------------------------------
module two_channel_window_average_framer_tb;
  import tcwaf_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 2 * (SUM_W + 2) + FRAME_LEN + 8;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int FILL_SAMPLES   = WINDOW_MAX_SAMPLES + 8;
  localparam int MAX_REPORTS    = 40;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = CFG_Y_CHANNEL + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST_INDEX   = '1;
  localparam logic [DATA_W-1:0]      SAMPLE_MAX       = '1;
  localparam logic [CHAN_W-1:0]      CHAN_MAX         = '1;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  two_channel_window_average_framer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [CHAN_W-1:0]  x_tap  = X_CHANNEL_RESET;
  logic [CHAN_W-1:0]  y_tap  = Y_CHANNEL_RESET;
  logic [SUM_W-1:0]   x_acc  = '0;
  logic [SUM_W-1:0]   y_acc  = '0;
  logic [COUNT_W-1:0] x_n    = '0;
  logic [COUNT_W-1:0] y_n    = '0;
  logic [DATA_W-1:0]  x_mean = '0;
  logic [DATA_W-1:0]  y_mean = '0;

  in_item_t  items_to_send[$];
  out_item_t frame_bytes_due[$];
  out_item_t due;

  int cycle_count    = 0;
  int mismatch_count = 0;
  int items_queued   = 0;
  int items_taken    = 0;
  int frames_seen    = 0;
  int cfg_writes     = 0;
  int tx_gap         = 0;
  int rx_gap         = 0;
  int rx_hold_left   = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  bit in_accepted    = 1'b0;
  bit no_idle        = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // running sums per window; a window end folds them into the held means
  task automatic average_and_frame(input in_item_t it);
    logic [7:0] bytes_out [FRAME_LEN];
    out_item_t  r;
    if (it.func == FUNC_SAMPLE) begin
      if (it.sample_channel == x_tap) begin
        if (x_n < WINDOW_MAX_SAMPLES) begin
          x_acc = x_acc + it.sample_value;
          x_n   = x_n + 1'b1;
        end
      end else if (it.sample_channel == y_tap) begin
        if (y_n < WINDOW_MAX_SAMPLES) begin
          y_acc = y_acc + it.sample_value;
          y_n   = y_n + 1'b1;
        end
      end
    end else begin
      // an empty window keeps the old mean
      if (x_n != 0) x_mean = DATA_W'(x_acc / x_n);
      if (y_n != 0) y_mean = DATA_W'(y_acc / y_n);
      bytes_out = '{CHR_AT, CHR_VERSION, CHR_R,
                    x_mean[7:0], 8'(x_mean[DATA_W-1:8]),
                    y_mean[7:0], 8'(y_mean[DATA_W-1:8]),
                    CHR_E, CHR_N, CHR_D, CHR_NL};
      for (int k = 0; k < FRAME_LEN; k++) begin
        r.frame_byte = bytes_out[k];
        r.last_byte  = (k == FRAME_LEN - 1);
        frame_bytes_due.push_back(r);
      end
      x_acc = '0;
      y_acc = '0;
      x_n   = '0;
      y_n   = '0;
    end
  endtask

  // monitor: everything sampled at the rising edge
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    in_accepted = 1'b0;
    if (rst) begin
      x_tap  = X_CHANNEL_RESET;
      y_tap  = Y_CHANNEL_RESET;
      x_acc  = '0;
      y_acc  = '0;
      x_n    = '0;
      y_n    = '0;
      x_mean = '0;
      y_mean = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        if (cfg_index == CFG_X_CHANNEL) begin
          x_tap = cfg_data;
        end else if (cfg_index == CFG_Y_CHANNEL) begin
          y_tap = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        in_accepted = 1'b1;
        items_taken++;
        average_and_frame(in_data);
      end
      if (out_valid && !out_stall) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch($sformatf("byte %02h last %0b with no byte due",
                                    out_data.frame_byte, out_data.last_byte));
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_data.frame_byte !== due.frame_byte ||
              out_data.last_byte !== due.last_byte) begin
            report_mismatch($sformatf("frame %0d: got %02h/%0b, want %02h/%0b",
                                      frames_seen, out_data.frame_byte,
                                      out_data.last_byte, due.frame_byte,
                                      due.last_byte));
          end
          if (due.last_byte) frames_seen++;
        end
      end
    end
  end

  // sender: next item only once the current one has gone
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (items_to_send.size() > 0 && !no_idle && $urandom_range(0, 5) == 0) begin
        tx_gap = $urandom_range(1, 8) - 1;
        in_valid <= 1'b0;
      end else if (items_to_send.size() > 0) begin
        in_data  <= items_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts plus an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served  = hold_requests;
      rx_hold_left = RX_HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 6) == 0) begin
      rx_gap = $urandom_range(1, 8) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_item(input logic f, input logic [CHAN_W-1:0] ch,
                            input logic [DATA_W-1:0] v);
    in_item_t it;
    it.func           = f;
    it.sample_channel = ch;
    it.sample_value   = v;
    items_to_send.push_back(it);
    items_queued++;
  endtask

  // mostly samples on the two selected channels, some stray tags and noise
  task automatic queue_random_window(input int n_samples);
    logic [CHAN_W-1:0] ch;
    logic [DATA_W-1:0] v;
    in_item_t          noise;
    int                pick;
    for (int i = 0; i < n_samples; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) ch = x_tap;
      else if (pick < 18) ch = y_tap;
      else ch = CHAN_W'($urandom);
      pick = $urandom_range(0, 9);
      v = (pick == 0) ? '0 : (pick == 1) ? SAMPLE_MAX : DATA_W'($urandom);
      if ($urandom_range(0, 24) == 0) begin
        noise = $bits(in_item_t)'($urandom);
        items_to_send.push_back(noise);
        items_queued++;
      end else begin
        queue_item(FUNC_SAMPLE, ch, v);
      end
    end
    queue_item(FUNC_WINDOW_END, CHAN_W'($urandom), DATA_W'($urandom));
  endtask

  // waits until every queued item is taken and every due frame byte has been seen
  task automatic drain();
    do @(posedge clk);
    while (items_to_send.size() != 0 || in_valid || frame_bytes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int budget);
    int start;
    start = items_queued;
    while (items_queued - start < budget) begin
      queue_random_window(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14));
    end
    drain();
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty windows after reset give zero means; ignored fields at extremes
    queue_item(FUNC_WINDOW_END, CHAN_MAX, SAMPLE_MAX);
    queue_item(FUNC_SAMPLE, X_CHANNEL_RESET, SAMPLE_MAX);
    queue_item(FUNC_SAMPLE, X_CHANNEL_RESET, SAMPLE_MAX);
    queue_item(FUNC_SAMPLE, Y_CHANNEL_RESET, '0);
    queue_item(FUNC_SAMPLE, 4'd9, 12'd1234);
    queue_item(FUNC_WINDOW_END, '0, '0);
    // truncation, y keeps its mean
    queue_item(FUNC_SAMPLE, X_CHANNEL_RESET, 12'd1);
    queue_item(FUNC_SAMPLE, X_CHANNEL_RESET, 12'd2);
    queue_item(FUNC_WINDOW_END, 4'd6, 12'd77);
    queue_item(FUNC_SAMPLE, Y_CHANNEL_RESET, SAMPLE_MAX);
    queue_item(FUNC_SAMPLE, Y_CHANNEL_RESET, 12'd4094);
    queue_item(FUNC_SAMPLE, Y_CHANNEL_RESET, 12'd4093);
    queue_item(FUNC_WINDOW_END, '0, SAMPLE_MAX);
    queue_item(FUNC_SAMPLE, '0, SAMPLE_MAX);
    queue_item(FUNC_WINDOW_END, CHAN_MAX, '0);
    drain();

    // both channels on one tag: x takes it all
    write_reg(CFG_X_CHANNEL, 4'd7);
    write_reg(CFG_Y_CHANNEL, 4'd7);
    queue_item(FUNC_SAMPLE, 4'd7, 12'd100);
    queue_item(FUNC_SAMPLE, 4'd7, 12'd201);
    queue_item(FUNC_SAMPLE, 4'd8, 12'd3000);
    queue_item(FUNC_WINDOW_END, '0, '0);
    drain();

    // writes past the register list change nothing
    write_reg(CFG_FIRST_UNUSED, CHAN_MAX);
    write_reg(CFG_LAST_INDEX, 4'd10);
    write_reg(CFG_X_CHANNEL, '0);
    write_reg(CFG_Y_CHANNEL, CHAN_MAX);
    queue_item(FUNC_SAMPLE, '0, '0);
    queue_item(FUNC_SAMPLE, CHAN_MAX, SAMPLE_MAX);
    queue_item(FUNC_WINDOW_END, 4'd7, 12'd5);
    drain();

    // overfill x past its cap, a few y samples mixed in; samples past the cap
    // are all max so a miss shows
    write_reg(CFG_X_CHANNEL, CHAN_MAX);
    write_reg(CFG_Y_CHANNEL, '0);
    for (int i = 0; i < FILL_SAMPLES; i++) begin
      queue_item(FUNC_SAMPLE, x_tap,
                 (i < WINDOW_MAX_SAMPLES) ? DATA_W'($urandom) : SAMPLE_MAX);
      if (i % 32 == 0) queue_item(FUNC_SAMPLE, y_tap, DATA_W'($urandom));
    end
    queue_item(FUNC_WINDOW_END, '0, '0);
    queue_random_window(4);
    drain();

    write_reg(CFG_X_CHANNEL, CHAN_W'($urandom));
    write_reg(CFG_Y_CHANNEL, CHAN_W'($urandom));
    run_random_phase(15);

    write_reg(CFG_X_CHANNEL, X_CHANNEL_RESET);
    write_reg(CFG_Y_CHANNEL, Y_CHANNEL_RESET);
    run_random_phase(15);

    write_reg(CFG_X_CHANNEL, 4'd9);
    write_reg(CFG_Y_CHANNEL, 4'd9);
    run_random_phase(15);

    // long output hold-off while items keep coming
    write_reg(CFG_X_CHANNEL, '0);
    write_reg(CFG_Y_CHANNEL, CHAN_MAX);
    hold_requests++;
    run_random_phase(20);

    // closing stretch at full rate on both sides
    no_idle = 1'b1;
    write_reg(CFG_X_CHANNEL, 4'd3);
    write_reg(CFG_Y_CHANNEL, 4'd12);
    run_random_phase(20);

    $display("run summary: %0d items taken, %0d frames checked, %0d register writes",
             items_taken, frames_seen, cfg_writes);
    $display("run summary: shared and split channels, capped windows, empty windows, "
             , "long output back-pressure");
    if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tcwaf_pkg.sv
hw/rtl/tcwaf_ctrl.sv
hw/rtl/tcwaf_dpath.sv
hw/rtl/two_channel_window_average_framer.sv
hw/rtl/tcwaf_checker.sv
verif/two_channel_window_average_framer_tb.sv
